// ===== rtl/ise_pkg.sv =====
// Shared types, constants and operation codes for the indexed stack engine.
`timescale 1ns / 1ps
package ise_pkg;

    localparam int ISE_STACK_DEPTH = 1024;
    localparam int ISE_WORD_WIDTH  = 32;

    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 10;
    localparam int COUNT_W = 11;
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd3;
    localparam logic [OP_W-1:0] OP_EXCHANGE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] push_value;
        logic [DEPTH_W-1:0] depth_a;
        logic [DEPTH_W-1:0] depth_b;
    } t_ise_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               ok;
        logic [COUNT_W-1:0] entry_count;
    } t_ise_rsp;

endpackage

// ===== rtl/ise_req_if.sv =====
// Request channel interface: valid, ready and one operation item.
`timescale 1ns / 1ps
interface ise_req_if
    import ise_pkg::*;
();
    logic     valid;
    logic     ready;
    t_ise_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ise_rsp_if.sv =====
// Response channel interface: valid, ready and one result item.
`timescale 1ns / 1ps
interface ise_rsp_if
    import ise_pkg::*;
();
    logic     valid;
    logic     ready;
    t_ise_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/indexed_stack_engine_unit.sv =====
// Top level of the indexed stack engine: sequencer, count and stack RAM.
//
//  channel  | dir | handshake             | item
//  ---------+-----+-----------------------+-------------------------------------------
//  i_req    | in  | valid/ready           | operation, push_value, depth_a, depth_b
//  o_rsp    | out | valid/ready           | read_value, ok, entry_count
//
// Push and refused items use execute and finish; pop and peek add a read wait,
// exchange two states and a write in finish, delete a read and a shift per entry above
// the deleted one; the single RAM port pair moves one word a cycle. Reset clears the
// count and the sequencer; the RAM is not cleared. A finished item waits in the output
// register while the next is taken; it completes once the output register is free.
`timescale 1ns / 1ps
module indexed_stack_engine_unit
    import ise_pkg::*;
#(
    parameter int STACK_DEPTH = ISE_STACK_DEPTH,
    parameter int WORD_WIDTH  = ISE_WORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ise_req_if.sink       i_req,
    ise_rsp_if.source     o_rsp
);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam int SUM_W = CNT_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_DEL0 = 3'd3;
    localparam logic [2:0] S_DELS = 3'd4;
    localparam logic [2:0] S_XB   = 3'd5;
    localparam logic [2:0] S_XW   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [DEPTH_W-1:0]    r_da, n_da, r_db, n_db;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx, r_cb, n_cb;
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic                  r_ok, n_ok;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_out_val, n_out_val;
    logic                  r_out_ok, n_out_ok;
    logic [COUNT_W-1:0]    r_out_cnt, n_out_cnt;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [WORD_WIDTH-1:0] w_wdata, w_rdata;

    logic [CMP_W-1:0]      w_cnt_c, w_da_c, w_db_c;
    logic                  w_da_ok, w_db_ok, w_not_full, w_not_empty;
    logic [AW-1:0]         w_top, w_cell_a, w_cell_b;
    logic [SUM_W-1:0]      w_cnt_s, w_nxt1, w_nxt2;
    logic                  w_in_acc, w_out_free;

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign w_cnt_c     = CMP_W'(r_count);
    assign w_da_c      = CMP_W'(r_da);
    assign w_db_c      = CMP_W'(r_db);
    assign w_da_ok     = w_da_c < w_cnt_c;
    assign w_db_ok     = w_db_c < w_cnt_c;
    assign w_not_full  = r_count < CNT_W'(STACK_DEPTH);
    assign w_not_empty = r_count != '0;
    assign w_top       = AW'(r_count - CNT_W'(1));
    assign w_cell_a    = AW'(w_cnt_c - w_da_c - CMP_W'(1));
    assign w_cell_b    = AW'(w_cnt_c - w_db_c - CMP_W'(1));
    assign w_cnt_s     = SUM_W'(r_count);
    assign w_nxt1      = SUM_W'(r_idx) + SUM_W'(1);
    assign w_nxt2      = SUM_W'(r_idx) + SUM_W'(2);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_word      = r_word;
        n_da        = r_da;
        n_db        = r_db;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cb        = r_cb;
        n_val       = r_val;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_ok    = r_out_ok;
        n_out_cnt   = r_out_cnt;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = r_idx;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op    = i_req.data.operation;
                    n_word  = WORD_WIDTH'(i_req.data.push_value);
                    n_da    = i_req.data.depth_a;
                    n_db    = i_req.data.depth_b;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_val   = '0;
                n_ok    = 1'b0;
                n_state = S_FIN;
                unique case (r_op)
                    OP_PUSH: begin
                        if (w_not_full) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_count);
                            w_wdata = r_word;
                            n_count = r_count + CNT_W'(1);
                            n_ok    = 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (w_not_empty) begin
                            w_re    = 1'b1;
                            w_raddr = w_top;
                            n_ok    = 1'b1;
                            n_state = S_RDW;
                            if (r_op == OP_POP) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (w_da_ok) begin
                            w_re    = 1'b1;
                            w_raddr = w_cell_a;
                            n_idx   = w_cell_a;
                            n_ok    = 1'b1;
                            n_state = S_DEL0;
                        end
                    end
                    OP_EXCHANGE: begin
                        if (w_da_ok && w_db_ok) begin
                            w_re    = 1'b1;
                            w_raddr = w_cell_a;
                            n_idx   = w_cell_a;
                            n_cb    = w_cell_b;
                            n_ok    = 1'b1;
                            n_state = S_XB;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDW: begin
                n_val   = w_rdata;
                n_state = S_FIN;
            end
            S_DEL0: begin
                n_val = w_rdata;
                if (w_nxt1 < w_cnt_s) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_nxt1);
                    n_state = S_DELS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end
            end
            S_DELS: begin
                // shift one entry down per cycle: write idx, prefetch idx+2
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = AW'(w_nxt1);
                if (w_nxt2 < w_cnt_s) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_nxt2);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end
            end
            S_XB: begin
                n_word  = w_rdata;
                w_re    = 1'b1;
                w_raddr = r_cb;
                n_state = S_XW;
            end
            S_XW: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                // second write reuses r_word through the FIN path below
                n_idx   = r_cb;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_op == OP_EXCHANGE && r_ok && r_idx == r_cb) begin
                    // exchange second write, once
                    w_we    = 1'b1;
                    w_waddr = r_cb;
                    w_wdata = r_word;
                    n_idx   = ~r_cb;
                end
                if (w_out_free && !(r_op == OP_EXCHANGE && r_ok && r_idx == r_cb)) begin
                    n_out_valid = 1'b1;
                    n_out_val   = (r_op == OP_EXCHANGE) ? '0 : VALUE_W'(r_val);
                    n_out_ok    = r_ok;
                    n_out_cnt   = COUNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_word    <= n_word;
        r_da      <= n_da;
        r_db      <= n_db;
        r_idx     <= n_idx;
        r_cb      <= n_cb;
        r_val     <= n_val;
        r_ok      <= n_ok;
        r_out_val <= n_out_val;
        r_out_ok  <= n_out_ok;
        r_out_cnt <= n_out_cnt;
    end

    ise_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready             = (r_state == S_IDLE);
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.data.read_value   = r_out_val;
    assign o_rsp.data.ok           = r_out_ok;
    assign o_rsp.data.entry_count  = r_out_cnt;
endmodule

// ===== rtl/ise_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module ise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ise_checker.sv =====
// Port-level checker for the indexed stack engine, bound to the top level.
`timescale 1ns / 1ps
module ise_checker
    import ise_pkg::*;
#(
    parameter int STACK_DEPTH = ISE_STACK_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] i_read_value,
    input logic               i_ok,
    input logic [COUNT_W-1:0] i_entry_count
);
    localparam int CHK_W = (COUNT_W > 32) ? COUNT_W : 32;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CHK_W'(i_entry_count) <= CHK_W'(STACK_DEPTH)))
        else $error("entry count above stack depth");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_ok) |-> (i_read_value == '0))
        else $error("refused item carries a nonzero word");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item taken while previous one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before it was taken");
endmodule

bind indexed_stack_engine_unit ise_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_ise_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_read_value  (o_rsp.data.read_value),
    .i_ok          (o_rsp.data.ok),
    .i_entry_count (o_rsp.data.entry_count)
);

// ===== test/tb_indexed_stack_engine_unit.sv =====
// Self-checking testbench for the indexed stack engine: mirrored stack against random traffic.
`timescale 1ns / 1ps
module tb_indexed_stack_engine_unit;
    import ise_pkg::*;

    localparam int QUIET_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 100;
    // codes past exchange are refused by the block
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    class stack_mirror;
        logic [VALUE_W-1:0] cells [ISE_STACK_DEPTH];
        int                 used;
        t_ise_rsp           pending_results [$];
        int                 error_count;

        function new();
            used        = 0;
            error_count = 0;
        endfunction

        task report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (error_count < PRINT_CAP) begin
                $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
            end
            error_count++;
        endtask

        // apply one accepted item to the mirrored stack and queue the result it causes
        function void take_request(t_ise_req req);
            t_ise_rsp           res;
            int                 pos_a;
            int                 pos_b;
            int                 i;
            logic [VALUE_W-1:0] tmp;
            res = '0;
            case (req.operation)
                OP_PUSH: begin
                    if (used < ISE_STACK_DEPTH) begin
                        cells[used] = req.push_value;
                        used++;
                        res.ok = 1'b1;
                    end
                end
                OP_POP: begin
                    if (used > 0) begin
                        used--;
                        res.read_value = cells[used];
                        res.ok = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (used > 0) begin
                        res.read_value = cells[used-1];
                        res.ok = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (int'(req.depth_a) < used) begin
                        pos_a = used - 1 - int'(req.depth_a);
                        res.read_value = cells[pos_a];
                        for (i = pos_a; i + 1 < used; i++) begin
                            cells[i] = cells[i+1];
                        end
                        used--;
                        res.ok = 1'b1;
                    end
                end
                OP_EXCHANGE: begin
                    if (int'(req.depth_a) < used && int'(req.depth_b) < used) begin
                        pos_a = used - 1 - int'(req.depth_a);
                        pos_b = used - 1 - int'(req.depth_b);
                        tmp = cells[pos_a];
                        cells[pos_a] = cells[pos_b];
                        cells[pos_b] = tmp;
                        res.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.entry_count = COUNT_W'(used);
            pending_results.push_back(res);
        endfunction

        task compare_result(t_ise_rsp got);
            t_ise_rsp want;
            if (pending_results.size() == 0) begin
                report("unrequested result", got.read_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                    report("read_value", got.read_value, want.read_value);
                if (got.ok !== want.ok)
                    report("ok", VALUE_W'(got.ok), VALUE_W'(want.ok));
                if (got.entry_count !== want.entry_count)
                    report("entry_count", VALUE_W'(got.entry_count), VALUE_W'(want.entry_count));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    bit          idle_on = 1'b1;
    int          quiet_cycles = 0;
    stack_mirror mirror;

    ise_req_if req_ch ();
    ise_rsp_if rsp_ch ();

    indexed_stack_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // results are checked before the same-edge request is noted
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            mirror.compare_result(rsp_ch.data);
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            mirror.take_request(req_ch.data);
        end
        if (i_rst_n && ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : result_sink
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) begin
                rsp_ch.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                hold = $urandom_range(0, 9);
            end else begin
                rsp_ch.ready <= 1'b1;
                hold = $urandom_range(0, 24);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                           logic [DEPTH_W-1:0] da, logic [DEPTH_W-1:0] db);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{operation: op, push_value: val, depth_a: da, depth_b: db};
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // mostly depths inside the stack, some on the boundary, some anywhere
    function automatic logic [DEPTH_W-1:0] pick_depth(int n);
        int r;
        r = $urandom_range(0, 9);
        if (n > 0 && r < 8) begin
            return DEPTH_W'($urandom_range(0, n - 1));
        end else if (r == 8 && n <= int'(DEPTH_MAX)) begin
            return DEPTH_W'(n);
        end
        return DEPTH_W'($urandom_range(0, int'(DEPTH_MAX)));
    endfunction

    task automatic send_random(int push_weight);
        int              pick;
        int              n;
        logic [OP_W-1:0] op;
        n = mirror.used;
        if ($urandom_range(0, 99) < push_weight) begin
            op = OP_PUSH;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      op = OP_POP;
            else if (pick < 40) op = OP_PEEK;
            else if (pick < 65) op = OP_DELETE;
            else if (pick < 92) op = OP_EXCHANGE;
            else                op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        send_op(op, $urandom, pick_depth(n), pick_depth(n));
    endtask

    initial begin : stimulus
        int i;
        mirror = new();
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack refusals and unused codes
        send_op(OP_POP, '0, '0, '0);
        send_op(OP_PEEK, '0, '0, '0);
        send_op(OP_DELETE, '0, '0, '0);
        send_op(OP_EXCHANGE, '0, '0, '0);
        send_op(OP_UNUSED_LO, '1, DEPTH_MAX, DEPTH_MAX);
        send_op(OP_UNUSED_HI, 32'h5555_5555, 10'h155, 10'h2AA);
        // value extremes, then depth edges on a four-entry stack
        send_op(OP_PUSH, '0, DEPTH_MAX, DEPTH_MAX);
        send_op(OP_PUSH, '1, '0, '0);
        send_op(OP_PUSH, 32'hA5A5_A5A5, '0, '0);
        send_op(OP_PUSH, 32'h5A5A_5A5A, '0, '0);
        send_op(OP_PEEK, '0, '0, '0);
        send_op(OP_EXCHANGE, '0, 10'd0, 10'd3);
        send_op(OP_EXCHANGE, '0, 10'd1, 10'd1);
        send_op(OP_EXCHANGE, '0, 10'd0, 10'd4);
        send_op(OP_EXCHANGE, '0, DEPTH_MAX, 10'd0);
        send_op(OP_DELETE, '0, 10'd4, '0);
        send_op(OP_DELETE, '0, DEPTH_MAX, '0);
        send_op(OP_DELETE, '0, 10'd3, '0);
        send_op(OP_DELETE, '0, 10'd0, '0);
        send_op(OP_POP, '0, '0, '0);
        send_op(OP_POP, '0, '0, '0);
        send_op(OP_POP, '0, '0, '0);
        send_op(OP_PUSH, 32'h1234_5678, '0, '0);
        send_op(OP_DELETE, '0, 10'd0, '0);

        // shallow stack traffic
        for (i = 0; i < 500; i++) begin
            send_random(mirror.used < 48 ? 35 : 12);
        end

        // fill to capacity, then work the full-stack edges
        while (mirror.used < ISE_STACK_DEPTH) begin
            send_random(95);
        end
        send_op(OP_PUSH, '1, '0, '0);
        send_op(OP_EXCHANGE, '0, 10'd0, DEPTH_MAX);
        send_op(OP_EXCHANGE, '0, DEPTH_MAX, DEPTH_MAX);
        send_op(OP_PEEK, '0, '0, '0);
        send_op(OP_DELETE, '0, DEPTH_MAX, '0);
        send_op(OP_PUSH, 32'hC3C3_3C3C, '0, '0);
        send_op(OP_DELETE, '0, 10'd0, '0);
        for (i = 0; i < 150; i++) begin
            send_random(60);
        end

        // no idling on either side from here on
        idle_on = 1'b0;
        for (i = 0; i < 200; i++) begin
            send_random(30);
        end
        req_ch.valid <= 1'b0;

        while (mirror.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
